/* sv/ttyld_pkg.sv */
// Shared types, codes and helpers of the tty line discipline ring buffer.
package ttyld_pkg;

  localparam int unsigned DefaultDepth = 128;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Command codes of a request word
  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_CANONICAL = 3'd0;
  localparam logic [2:0] REG_IGNORE_CR = 3'd1;
  localparam logic [2:0] REG_CR_TO_NL  = 3'd2;
  localparam logic [2:0] REG_NL_TO_CR  = 3'd3;
  localparam logic [2:0] REG_FOLD      = 3'd4;
  localparam logic [2:0] REG_ECHO      = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_char;
  } req_word_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic [7:0] echo_char;
    logic       echo_valid;
    logic       erase_request;
    logic       input_ready;
    logic       dropped_full;
    logic       delete_refused;
    logic [7:0] fill_count;
    logic [7:0] lines_pending;
  } rsp_word_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] value;
  } cfg_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the request and launch the buffer read
    logic commit;  // update the buffer state and load the result register
  } ctrl_cmd_t;

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_NL) || (c == CH_CR);
  endfunction

endpackage

/* sv/ttyld_chan_if.sv */
// Valid/ready channel carrying one word of a given payload type.
interface ttyld_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/ttyld_ctrl.sv */
// Controller: sequences one request through read and commit, owns result valid.
module ttyld_ctrl
  import ttyld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic rsp_valid_q, rsp_valid_d;

  assign req_ready_o  = (state_q == S_IDLE);
  assign cmd_o.load   = req_valid_i & req_ready_o;
  // Commit only when the result register is free or being emptied.
  assign cmd_o.commit = (state_q == S_EXEC) & (~rsp_valid_q | rsp_ready_i);
  assign rsp_valid_o  = rsp_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

/* sv/ttyld_dp.sv */
// Datapath: config registers, key translation, character ring buffer, result register.
module ttyld_dp
  import ttyld_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  req_word_t req_i,
  input  logic      cfg_we_i,
  input  cfg_word_t cfg_i,
  output rsp_word_t rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = (CW > 8) ? CW : 8;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Configuration registers
  logic canonical_q, ignore_cr_q, cr_to_nl_q, nl_to_cr_q, fold_q, echo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canonical_q <= 1'b1;
      ignore_cr_q <= 1'b0;
      cr_to_nl_q  <= 1'b1;
      nl_to_cr_q  <= 1'b0;
      fold_q      <= 1'b0;
      echo_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_i.index)
        REG_CANONICAL: canonical_q <= cfg_i.value[0];
        REG_IGNORE_CR: ignore_cr_q <= cfg_i.value[0];
        REG_CR_TO_NL:  cr_to_nl_q  <= cfg_i.value[0];
        REG_NL_TO_CR:  nl_to_cr_q  <= cfg_i.value[0];
        REG_FOLD:      fold_q      <= cfg_i.value[0];
        REG_ECHO:      echo_q      <= cfg_i.value[0];
        default: ;
      endcase
    end
  end

  // Buffer state
  logic [AW-1:0] wi_q, wi_d, ri_q, ri_d;
  logic          full_q, full_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Latched request
  logic [1:0]    op_q;
  logic [7:0]    char_q;
  logic          skip_q, del_q;
  logic [7:0]    rd_q;

  logic [7:0]    mem [DEPTH];

  // Key translation
  logic [7:0]    tr_char;
  logic          tr_skip;
  logic [AW-1:0] prev_idx;
  logic [AW-1:0] rd_addr;

  always_comb begin
    tr_char = req_i.key_char;
    tr_skip = 1'b0;
    if (req_i.key_char == CH_CR) begin
      if (ignore_cr_q) begin
        tr_skip = 1'b1;
      end else if (cr_to_nl_q) begin
        tr_char = CH_NL;
      end
    end else if ((req_i.key_char == CH_NL) && nl_to_cr_q) begin
      tr_char = CH_CR;
    end
    if (fold_q && (tr_char inside {[CH_UP_A:CH_UP_Z]})) begin
      tr_char = tr_char + CASE_GAP;
    end
    if (!canonical_q) begin
      tr_char = req_i.key_char;
      tr_skip = 1'b0;
    end
  end

  assign prev_idx = (wi_q == '0) ? LAST : wi_q - 1'b1;
  assign rd_addr  = (req_i.cmd == CMD_READ) ? ri_q : prev_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= req_i.cmd;
      char_q <= tr_char;
      skip_q <= tr_skip;
      del_q  <= canonical_q & ~tr_skip & ((tr_char == CH_DEL) || (tr_char == CH_BS));
      rd_q   <= mem[rd_addr];
    end
  end

  // Commit: next buffer state and result
  logic          empty;
  logic          we;
  logic [AW-1:0] wi_inc, ri_inc;
  rsp_word_t     rsp_d;
  logic [CW-1:0] fill;
  logic [SW-1:0] fill_ext, cnt_ext;

  assign empty  = (wi_q == ri_q) & ~full_q;
  assign wi_inc = (wi_q == LAST) ? '0 : wi_q + 1'b1;
  assign ri_inc = (ri_q == LAST) ? '0 : ri_q + 1'b1;

  always_comb begin
    wi_d   = wi_q;
    ri_d   = ri_q;
    full_d = full_q;
    cnt_d  = cnt_q;
    we     = 1'b0;
    rsp_d  = '0;
    case (op_q)
      CMD_KEY: begin
        if (skip_q) begin
          // drop the carriage return, report counts only
        end else if (del_q) begin
          if (!empty) begin
            if (is_delim(rd_q)) begin
              rsp_d.delete_refused = 1'b1;
            end else begin
              wi_d                = (wi_q == '0) ? LAST : wi_q - 1'b1;
              full_d              = 1'b0;
              rsp_d.erase_request = 1'b1;
            end
          end
        end else begin
          if (full_q) begin
            rsp_d.dropped_full = 1'b1;
          end else begin
            we     = 1'b1;
            wi_d   = wi_inc;
            full_d = (wi_inc == ri_q);
            if (is_delim(char_q)) cnt_d = cnt_q + 1'b1;
          end
          if (canonical_q) begin
            rsp_d.input_ready = (cnt_d != '0);
            if (echo_q) begin
              rsp_d.echo_char  = char_q;
              rsp_d.echo_valid = 1'b1;
            end
          end else begin
            rsp_d.input_ready = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (!empty) begin
          ri_d   = ri_inc;
          full_d = 1'b0;
          if (is_delim(rd_q) && (cnt_q != '0)) cnt_d = cnt_q - 1'b1;
          rsp_d.read_char  = rd_q;
          rsp_d.read_valid = 1'b1;
        end
      end
      CMD_CLEAR: begin
        wi_d   = '0;
        ri_d   = '0;
        full_d = 1'b0;
        cnt_d  = '0;
      end
      default: ;
    endcase

    if (full_d) begin
      fill = CW'(DEPTH);
    end else if (wi_d >= ri_d) begin
      fill = CW'(wi_d) - CW'(ri_d);
    end else begin
      fill = CW'(wi_d) + CW'(DEPTH) - CW'(ri_d);
    end
    fill_ext            = SW'(fill);
    cnt_ext             = SW'(cnt_d);
    rsp_d.fill_count    = (fill_ext > SW'(255)) ? 8'hFF : fill_ext[7:0];
    rsp_d.lines_pending = (cnt_ext > SW'(255)) ? 8'hFF : cnt_ext[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      ri_q   <= '0;
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      wi_q   <= wi_d;
      ri_q   <= ri_d;
      full_q <= full_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      mem[wi_q] <= char_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_o <= rsp_d;
    end
  end

endmodule

/* sv/tty_line_discipline_ring_buffer.sv */
// Top level of the tty line discipline ring buffer.
//
// Keyboard line discipline in front of a DEPTH-byte character ring buffer.
// Each request word (key, read or clear) yields exactly one result word.
// A request is first loaded, which latches the translated key and
// reads the one buffer entry it needs (the newest character for a delete,
// the oldest for a read) from the registered-read buffer memory, and then
// committed, which updates pointers, full flag and delimiter count and
// loads the result register. No new request is taken until the last one
// has committed; the commit waits only while the previous result is still
// held unread. Configuration writes are registered and always accepted;
// write them only while no request is in flight. Buffer contents need no
// clearing after reset: entries are only used once written.
module tty_line_discipline_ring_buffer
  import ttyld_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttyld_chan_if.sink   req_i,
  ttyld_chan_if.source rsp_o,
  ttyld_chan_if.sink   cfg_i
);

  ctrl_cmd_t ctrl_cmd;
  req_word_t req_word;
  cfg_word_t cfg_word;
  rsp_word_t rsp_word;

  assign req_word    = req_i.data;
  assign cfg_word    = cfg_i.data;
  // Config writes are registered directly: always ready.
  assign cfg_i.ready = 1'b1;
  assign rsp_o.data  = rsp_word;

  ttyld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  ttyld_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (ctrl_cmd),
    .req_i    (req_word),
    .cfg_we_i (cfg_i.valid),
    .cfg_i    (cfg_word),
    .rsp_o    (rsp_word)
  );

endmodule

/* sv/ttyld_checker.sv */
// Port-level checks of the tty line discipline ring buffer, bound to the top level.
module ttyld_checker
  import ttyld_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_ready_i,
  input logic      rsp_valid_i,
  input logic      rsp_ready_i,
  input rsp_word_t rsp_word_i
);

  // Hold a result until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before it was taken");

  // One request in flight: no accept in the cycle after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  // Delimiters are a subset of the held characters.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_word_i.lines_pending <= rsp_word_i.fill_count)
    else $error("more lines pending than characters held");

  // Character fields read zero unless flagged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_word_i.read_valid || rsp_word_i.read_char == 8'h00) &&
                    (rsp_word_i.echo_valid || rsp_word_i.echo_char == 8'h00))
    else $error("character field set without its valid flag");

endmodule

bind tty_line_discipline_ring_buffer ttyld_checker u_ttyld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_word_i  (rsp_o.data)
);
